// ===== hw/rtl/dq_pkg.sv =====
// Package for the double-ended queue: sizes, request and status codes,
// and the ring index helpers.
// Depends on nothing; used by double_ended_queue and dq_checker.
`default_nettype none

package dq_pkg;

  // Ring size and derived widths.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed widths of the word fields.
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Step an index forward around the ring.
  function automatic idx_t ring_next(input idx_t i);
    return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // Step an index backward around the ring.
  function automatic idx_t ring_prev(input idx_t i);
    return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words on a ring buffer memory.
// The result strobe is registered and rises in the cycle after the word is accepted.
// Throughput: one word per cycle unless busy; a word does at most one slot write
// and two slot reads (front and back) in the same memory access cycle, with write forwarding.
// Reset: synchronous rst clears head, tail and count; slot contents stay
// undefined, busy is high while rst is held. The receiver cannot stall.
`default_nettype none

module double_ended_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dq_pkg::REQ_W-1:0]      req_type,
  input  wire logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                               done,
  output logic signed [dq_pkg::DATA_W-1:0]   front_value,
  output logic signed [dq_pkg::DATA_W-1:0]   back_value,
  output logic [dq_pkg::COUNT_W-1:0]         entry_count,
  output logic                               is_empty,
  output logic [dq_pkg::STATUS_W-1:0]        status
);
  import dq_pkg::*;

  // Slot storage: one write port, two read ports, registered read data.
  logic [DATA_W-1:0] slots [CAPACITY];

  idx_t head, head_next;
  idx_t tail, tail_next;
  cnt_t occupancy, occupancy_next;

  logic                accept;
  logic                wr_en;
  idx_t                wr_addr;
  idx_t                rd_front_addr, rd_back_addr;
  logic [STATUS_W-1:0] st;

  logic [DATA_W-1:0]   rd_front, rd_back, wr_data_q;
  logic                fwd_front, fwd_back;
  cnt_t                count_q;
  logic [STATUS_W-1:0] status_q;

  assign busy   = rst;
  assign accept = start & ~busy;

  // Pointer and count update for the incoming request.
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    st             = ST_OK;
    wr_en          = 1'b0;
    wr_addr        = tail;
    case (req_type)
      REQ_PUSH_FRONT: begin
        if (occupancy == CNT_FULL) begin
          st = ST_PUSH_FULL;
        end else begin
          head_next      = ring_prev(head);
          wr_en          = 1'b1;
          wr_addr        = ring_prev(head);
          occupancy_next = cnt_t'(occupancy + 1'b1);
        end
      end
      REQ_PUSH_BACK: begin
        if (occupancy == CNT_FULL) begin
          st = ST_PUSH_FULL;
        end else begin
          tail_next      = ring_next(tail);
          wr_en          = 1'b1;
          wr_addr        = tail;
          occupancy_next = cnt_t'(occupancy + 1'b1);
        end
      end
      REQ_POP_FRONT: begin
        if (occupancy == '0) begin
          st = ST_POP_EMPTY;
        end else begin
          head_next      = ring_next(head);
          occupancy_next = cnt_t'(occupancy - 1'b1);
        end
      end
      REQ_POP_BACK: begin
        if (occupancy == '0) begin
          st = ST_POP_EMPTY;
        end else begin
          tail_next      = ring_prev(tail);
          occupancy_next = cnt_t'(occupancy - 1'b1);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // The front and back slots after the update.
  assign rd_front_addr = head_next;
  assign rd_back_addr  = ring_prev(tail_next);

  // Memory access: write the pushed word and read both ends in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en) begin
        slots[wr_addr] <= value;
      end
      rd_front <= slots[rd_front_addr];
      rd_back  <= slots[rd_back_addr];
    end
  end

  // Forwarding of the word written in the same cycle as the reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_data_q <= value;
      fwd_front <= wr_en && (wr_addr == rd_front_addr);
      fwd_back  <= wr_en && (wr_addr == rd_back_addr);
      count_q   <= occupancy_next;
      status_q  <= st;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        head      <= head_next;
        tail      <= tail_next;
        occupancy <= occupancy_next;
      end
    end
  end

  // Result word; both ends read as zero when the queue is empty.
  assign is_empty    = (count_q == '0);
  assign entry_count = COUNT_W'(count_q);
  assign status      = status_q;
  assign front_value = is_empty ? '0 : (fwd_front ? wr_data_q : rd_front);
  assign back_value  = is_empty ? '0 : (fwd_back ? wr_data_q : rd_back);

endmodule

`default_nettype wire

// ===== hw/rtl/dq_checker.sv =====
// Port-level checks for the double-ended queue, bound into double_ended_queue.
// Depends on dq_pkg and double_ended_queue.
`default_nettype none

module dq_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic signed [dq_pkg::DATA_W-1:0]  front_value,
  input wire logic signed [dq_pkg::DATA_W-1:0]  back_value,
  input wire logic [dq_pkg::COUNT_W-1:0]        entry_count,
  input wire logic                              is_empty,
  input wire logic [dq_pkg::STATUS_W-1:0]       status
);
  import dq_pkg::*;

  // Every accepted word gives exactly one result in the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("result strobe missing after accepted word");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without accepted word");

  // An empty queue shows zero at both ends and a matching flag.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)) &&
             (!is_empty || (front_value == '0 && back_value == '0)))
    else $error("empty flag or end values inconsistent");

  // A refused pop leaves the queue empty.
  a_pop_refused: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_POP_EMPTY) |-> is_empty)
    else $error("pop refused on non-empty queue");

  // A refused push leaves the queue full.
  a_push_refused: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_PUSH_FULL) |-> (entry_count == COUNT_W'(CAPACITY)))
    else $error("push refused on non-full queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .front_value (front_value),
  .back_value  (back_value),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .status      (status)
);

`default_nettype wire
